>>> rtl/canonical_huffman_bit_decoder_top_assert.svh
// Assertion macros for the canonical Huffman bit decoder.
// Included by the checker module; needs nothing else.
`ifndef CANONICAL_HUFFMAN_BIT_DECODER_TOP_ASSERT_SVH
`define CANONICAL_HUFFMAN_BIT_DECODER_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CHBD_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CHBD_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/chbd_pkg.sv
// Shared types and constants for the canonical Huffman bit decoder.
// Used by the front end, the back end, the top level and the checker.
package chbd_pkg;

    localparam int MaxCodeBits = 16;
    localparam int MaxSymbols  = 256;

    localparam int OpcodeW  = 2;
    localparam int SlotW    = 8;
    localparam int ByteW    = 8;
    localparam int TotalW   = 9;
    localparam int StatusW  = 3;
    localparam int CodeLenW = 5;

    localparam int QueueDepth = 2;

    typedef enum logic [OpcodeW-1:0] {
        OP_WRITE_COUNT  = 2'd0,
        OP_WRITE_SYMBOL = 2'd1,
        OP_COMMIT       = 2'd2,
        OP_DECODE       = 2'd3
    } opcode_t;

    typedef enum logic [StatusW-1:0] {
        ST_NONE      = 3'd0,
        ST_SYMBOL    = 3'd1,
        ST_INVALID   = 3'd2,
        ST_TABLE_ERR = 3'd3,
        ST_NOT_READY = 3'd4
    } status_t;

    typedef enum logic {
        BK_RUN  = 1'b0,
        BK_WALK = 1'b1
    } back_state_t;

    // One classified item as it waits between front end and back end.
    typedef struct packed {
        opcode_t            opcode;
        logic [SlotW-1:0]   slot;
        logic [ByteW-1:0]   byte_value;
        logic [TotalW-1:0]  symbol_total;
        logic               code_bit;
        logic               slot_ok;
        logic               total_ok;
    } cmd_t;

endpackage

>>> rtl/chbd_front.sv
// Front end of the canonical Huffman bit decoder: takes input transfers,
// classifies them and holds them in a short queue. Depends on chbd_pkg.
module chbd_front #(
    parameter int MAX_CODE_BITS = chbd_pkg::MaxCodeBits,
    parameter int MAX_SYMBOLS   = chbd_pkg::MaxSymbols
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [chbd_pkg::OpcodeW-1:0]  s_opcode,
    input  logic [chbd_pkg::SlotW-1:0]    s_slot,
    input  logic [chbd_pkg::ByteW-1:0]    s_byte_value,
    input  logic [chbd_pkg::TotalW-1:0]   s_symbol_total,
    input  logic                          s_code_bit,
    output chbd_pkg::cmd_t                cmd,
    output logic                          cmd_valid,
    input  logic                          cmd_ready
);
    import chbd_pkg::*;

    localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
    localparam int CntW = $clog2(QueueDepth + 1);

    cmd_t            queue_reg [QueueDepth];
    logic [PtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0] count_reg, count_next;
    cmd_t            incoming;
    logic            push, pop;

    // Range checks are done here so the back end only acts on flags.
    always_comb begin
        incoming.opcode       = opcode_t'(s_opcode);
        incoming.slot         = s_slot;
        incoming.byte_value   = s_byte_value;
        incoming.symbol_total = s_symbol_total;
        incoming.code_bit     = s_code_bit;
        incoming.total_ok     = s_symbol_total <= TotalW'(MAX_SYMBOLS);
        case (opcode_t'(s_opcode))
            OP_WRITE_COUNT:  incoming.slot_ok = {1'b0, s_slot} < TotalW'(MAX_CODE_BITS);
            OP_WRITE_SYMBOL: incoming.slot_ok = {1'b0, s_slot} < TotalW'(MAX_SYMBOLS);
            default:         incoming.slot_ok = 1'b0;
        endcase
    end

    assign s_ready   = count_reg != CntW'(QueueDepth);
    assign cmd_valid = count_reg != '0;
    assign cmd       = queue_reg[rd_ptr_reg];
    assign push      = s_valid && s_ready;
    assign pop       = cmd_valid && cmd_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            queue_reg[wr_ptr_reg] <= incoming;
        end
    end

endmodule

>>> rtl/chbd_back.sv
// Back end of the canonical Huffman bit decoder: table storage, the commit
// walk over code lengths, bit-serial decoding and the result register.
// Depends on chbd_pkg.
module chbd_back #(
    parameter int MAX_CODE_BITS = chbd_pkg::MaxCodeBits,
    parameter int MAX_SYMBOLS   = chbd_pkg::MaxSymbols
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  chbd_pkg::cmd_t                 cmd,
    input  logic                           cmd_valid,
    output logic                           cmd_ready,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [chbd_pkg::StatusW-1:0]   m_status,
    output logic [chbd_pkg::ByteW-1:0]     m_symbol,
    output logic [chbd_pkg::CodeLenW-1:0]  m_code_length
);
    import chbd_pkg::*;

    localparam int LenIdxW  = (MAX_CODE_BITS > 1) ? $clog2(MAX_CODE_BITS) : 1;
    localparam int LenW     = $clog2(MAX_CODE_BITS + 1);
    localparam int CodeW    = MAX_CODE_BITS;
    localparam int FirstW   = MAX_CODE_BITS + 1;
    localparam int DiffW    = (FirstW > ByteW) ? FirstW : ByteW;
    localparam int AccW     = ((MAX_CODE_BITS > ByteW) ? MAX_CODE_BITS : ByteW) + 2;
    localparam int SumRawW  = $clog2(MAX_CODE_BITS * 255 + 1);
    localparam int SumW     = (SumRawW > TotalW) ? SumRawW : TotalW;
    localparam int SymAddrW = $clog2(MAX_SYMBOLS);

    // Table state.
    logic [ByteW-1:0]    counts_reg [MAX_CODE_BITS];
    logic [FirstW-1:0]   first_reg  [MAX_CODE_BITS];
    logic [TotalW-1:0]   offset_reg [MAX_CODE_BITS];
    logic [ByteW-1:0]    sym_mem    [MAX_SYMBOLS];
    logic [ByteW-1:0]    sym_rdata_reg;
    logic                ready_reg, ready_next;
    logic [LenW-1:0]     last_len_reg, last_len_next;
    logic [FirstW-1:0]   last_code_reg, last_code_next;

    // Code assembly state.
    logic [CodeW-1:0]    code_reg, code_next;
    logic [LenW-1:0]     bits_reg, bits_next;

    // Commit walk.
    back_state_t         state_reg, state_next;
    logic [LenIdxW-1:0]  walk_idx_reg, walk_idx_next;
    logic [AccW-1:0]     acc_code_reg, acc_code_next;
    logic [SumW-1:0]     acc_sum_reg, acc_sum_next;
    logic                walk_fail_reg, walk_fail_next;
    logic [TotalW-1:0]   walk_total_reg, walk_total_next;
    logic                walk_total_ok_reg, walk_total_ok_next;

    // Result register.
    logic                out_valid_reg, out_valid_next;
    status_t             out_status_reg, out_status_next;
    logic                out_from_mem_reg, out_from_mem_next;
    logic [CodeLenW-1:0] out_len_reg, out_len_next;

    // Control and datapath signals.
    logic                out_free, fire, walk_last, walk_adv, res_push;
    logic [LenIdxW-1:0]  dec_idx, rd_idx;
    logic [ByteW-1:0]    cnt;
    logic [CodeW-1:0]    c;
    logic [FirstW-1:0]   c_ext;
    logic [DiffW-1:0]    diff;
    logic                hit, alive;
    logic [LenW-1:0]     len, shamt;
    logic [TotalW:0]     sym_index;
    logic [AccW-1:0]     acc_add;
    logic                step_fail;
    logic [SumW-1:0]     sum_add;
    logic                commit_ok;
    logic                count_we, sym_we, sym_re;

    assign out_free  = !out_valid_reg || m_ready;
    assign walk_last = walk_idx_reg == LenIdxW'(MAX_CODE_BITS - 1);

    // Next state of the back end sequencer.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            BK_RUN: begin
                if (fire && cmd.opcode == OP_COMMIT) begin
                    state_next = BK_WALK;
                end
            end
            BK_WALK: begin
                if (walk_adv && walk_last) begin
                    state_next = BK_RUN;
                end
            end
            default: state_next = BK_RUN;
        endcase
    end

    // Sequencer outputs.
    always_comb begin
        cmd_ready = 1'b0;
        walk_adv  = 1'b0;
        case (state_reg)
            BK_RUN:  cmd_ready = out_free;
            BK_WALK: walk_adv  = !walk_last || out_free;
            default: cmd_ready = 1'b0;
        endcase
    end

    assign fire     = cmd_valid && cmd_ready;
    assign res_push = (fire && cmd.opcode != OP_COMMIT) || (walk_adv && walk_last);

    // Decode datapath: the count table has one read port shared with the walk.
    assign dec_idx = bits_reg[LenIdxW-1:0];
    assign rd_idx  = (state_reg == BK_WALK) ? walk_idx_reg : dec_idx;
    assign cnt     = counts_reg[rd_idx];
    assign c       = CodeW'({code_reg, cmd.code_bit});
    assign c_ext   = FirstW'(c);
    assign diff    = DiffW'(c_ext) - DiffW'(first_reg[dec_idx]);
    assign hit     = (c_ext >= first_reg[dec_idx]) && (diff < DiffW'(cnt));
    assign len     = bits_reg + LenW'(1);
    assign shamt   = last_len_reg - len;
    assign alive   = (last_len_reg > len) && (c_ext <= (last_code_reg >> shamt));
    assign sym_index = (TotalW + 1)'(offset_reg[dec_idx]) + (TotalW + 1)'(diff[ByteW-1:0]);

    // Commit walk datapath: one code length per cycle; the last length waits for a free result register.
    assign acc_add   = acc_code_reg + AccW'(cnt);
    assign step_fail = acc_add > (AccW'(2) << walk_idx_reg);
    assign sum_add   = acc_sum_reg + SumW'(cnt);
    assign commit_ok = !walk_fail_reg && !step_fail && walk_total_ok_reg
                       && (sum_add == SumW'(walk_total_reg));

    always_comb begin
        ready_next         = ready_reg;
        last_len_next      = last_len_reg;
        last_code_next     = last_code_reg;
        code_next          = code_reg;
        bits_next          = bits_reg;
        walk_idx_next      = walk_idx_reg;
        acc_code_next      = acc_code_reg;
        acc_sum_next       = acc_sum_reg;
        walk_fail_next     = walk_fail_reg;
        walk_total_next    = walk_total_reg;
        walk_total_ok_next = walk_total_ok_reg;
        out_status_next    = out_status_reg;
        out_from_mem_next  = out_from_mem_reg;
        out_len_next       = out_len_reg;
        count_we           = 1'b0;
        sym_we             = 1'b0;
        sym_re             = 1'b0;

        if (res_push) begin
            out_status_next   = ST_NONE;
            out_from_mem_next = 1'b0;
            out_len_next      = '0;
        end

        if (fire) begin
            case (cmd.opcode)
                OP_WRITE_COUNT: begin
                    count_we   = cmd.slot_ok;
                    ready_next = 1'b0;
                    code_next  = '0;
                    bits_next  = '0;
                end
                OP_WRITE_SYMBOL: begin
                    sym_we     = cmd.slot_ok;
                    ready_next = 1'b0;
                    code_next  = '0;
                    bits_next  = '0;
                end
                OP_COMMIT: begin
                    ready_next         = 1'b0;
                    code_next          = '0;
                    bits_next          = '0;
                    walk_idx_next      = '0;
                    acc_code_next      = '0;
                    acc_sum_next       = '0;
                    walk_fail_next     = 1'b0;
                    walk_total_next    = cmd.symbol_total;
                    walk_total_ok_next = cmd.total_ok;
                    last_len_next      = '0;
                    last_code_next     = '0;
                end
                OP_DECODE: begin
                    if (!ready_reg) begin
                        out_status_next = ST_NOT_READY;
                    end else if (hit) begin
                        out_status_next   = ST_SYMBOL;
                        out_from_mem_next = 1'b1;
                        out_len_next      = CodeLenW'(len);
                        sym_re            = 1'b1;
                        code_next         = '0;
                        bits_next         = '0;
                    end else if (alive) begin
                        code_next = c;
                        bits_next = len;
                    end else begin
                        out_status_next = ST_INVALID;
                        code_next       = '0;
                        bits_next       = '0;
                    end
                end
                default: begin
                    ready_next = ready_reg;
                end
            endcase
        end

        if (walk_adv) begin
            walk_idx_next  = walk_last ? '0 : walk_idx_reg + 1'b1;
            acc_code_next  = acc_add << 1;
            acc_sum_next   = sum_add;
            walk_fail_next = walk_fail_reg || step_fail;
            if (cnt != '0) begin
                last_len_next  = LenW'(walk_idx_reg) + LenW'(1);
                last_code_next = FirstW'(acc_add - AccW'(1));
            end
            if (walk_last) begin
                ready_next      = commit_ok;
                out_status_next = commit_ok ? ST_NONE : ST_TABLE_ERR;
            end
        end

        if (res_push) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= BK_RUN;
            ready_reg     <= 1'b0;
            last_len_reg  <= '0;
            last_code_reg <= '0;
            code_reg      <= '0;
            bits_reg      <= '0;
            walk_idx_reg  <= '0;
            walk_fail_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < MAX_CODE_BITS; i++) begin
                counts_reg[i] <= '0;
                first_reg[i]  <= '0;
                offset_reg[i] <= '0;
            end
        end else begin
            state_reg     <= state_next;
            ready_reg     <= ready_next;
            last_len_reg  <= last_len_next;
            last_code_reg <= last_code_next;
            code_reg      <= code_next;
            bits_reg      <= bits_next;
            walk_idx_reg  <= walk_idx_next;
            walk_fail_reg <= walk_fail_next;
            out_valid_reg <= out_valid_next;
            if (count_we) begin
                counts_reg[cmd.slot[LenIdxW-1:0]] <= cmd.byte_value;
            end
            if (walk_adv) begin
                first_reg[walk_idx_reg]  <= FirstW'(acc_code_reg);
                offset_reg[walk_idx_reg] <= TotalW'(acc_sum_reg);
            end
        end
    end

    always_ff @(posedge aclk) begin
        acc_code_reg      <= acc_code_next;
        acc_sum_reg       <= acc_sum_next;
        walk_total_reg    <= walk_total_next;
        walk_total_ok_reg <= walk_total_ok_next;
        out_status_reg    <= out_status_next;
        out_from_mem_reg  <= out_from_mem_next;
        out_len_reg       <= out_len_next;
    end

    // Symbol store: one write port, one registered read port.
    always_ff @(posedge aclk) begin
        if (sym_we) begin
            sym_mem[cmd.slot[SymAddrW-1:0]] <= cmd.byte_value;
        end
        if (sym_re) begin
            sym_rdata_reg <= sym_mem[sym_index[SymAddrW-1:0]];
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_status      = out_status_reg;
    assign m_symbol      = out_from_mem_reg ? sym_rdata_reg : '0;
    assign m_code_length = out_len_reg;

endmodule

>>> rtl/canonical_huffman_bit_decoder_top.sv
// Canonical Huffman bit decoder (JPEG-style tables), one result transfer for
// every input transfer, in order. A steady stream of decode bits is decoded
// at one bit per cycle while m_ready stays high. A commit runs a sequential
// walk over the count table, one code length per cycle, which builds the first
// code and symbol offset of each length; the last length waits for a free
// result register. Load items are length counts and symbol bytes. A two-entry
// queue between the front end and the back end keeps input transfers flowing
// while the back end walks or while the result register waits on m_ready;
// at the earliest, a result is valid once its input transfer has passed the
// queue and then the result register.
// A table must be committed after its last load before bits are decoded;
// until then every decode bit reports "table not committed". Symbol entries
// that were never written hold arbitrary data, so a table must only refer to
// loaded symbols. The symbol store comes out of reset unwritten and needs no
// clearing pass; the count and code tables reset to zero at once.
// Depends on chbd_pkg, chbd_front and chbd_back.
module canonical_huffman_bit_decoder_top #(
    parameter int MAX_CODE_BITS = chbd_pkg::MaxCodeBits,
    parameter int MAX_SYMBOLS   = chbd_pkg::MaxSymbols
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [chbd_pkg::OpcodeW-1:0]   s_opcode,
    input  logic [chbd_pkg::SlotW-1:0]     s_slot,
    input  logic [chbd_pkg::ByteW-1:0]     s_byte_value,
    input  logic [chbd_pkg::TotalW-1:0]    s_symbol_total,
    input  logic                           s_code_bit,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [chbd_pkg::StatusW-1:0]   m_status,
    output logic [chbd_pkg::ByteW-1:0]     m_symbol,
    output logic [chbd_pkg::CodeLenW-1:0]  m_code_length
);
    import chbd_pkg::*;

    // Classified items waiting for the back end.
    cmd_t cmd;
    logic cmd_valid;
    logic cmd_ready;

    // The front end checks slot and total ranges against the parameters and
    // queues each transfer, so input stalls only when the queue is full.
    chbd_front #(
        .MAX_CODE_BITS (MAX_CODE_BITS),
        .MAX_SYMBOLS   (MAX_SYMBOLS)
    ) u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_opcode       (s_opcode),
        .s_slot         (s_slot),
        .s_byte_value   (s_byte_value),
        .s_symbol_total (s_symbol_total),
        .s_code_bit     (s_code_bit),
        .cmd            (cmd),
        .cmd_valid      (cmd_valid),
        .cmd_ready      (cmd_ready)
    );

    // The back end owns all table state and the result register. It takes a
    // new item whenever it is not walking and the result register is empty or being drained.
    chbd_back #(
        .MAX_CODE_BITS (MAX_CODE_BITS),
        .MAX_SYMBOLS   (MAX_SYMBOLS)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .cmd_valid     (cmd_valid),
        .cmd_ready     (cmd_ready),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_symbol      (m_symbol),
        .m_code_length (m_code_length)
    );

endmodule

>>> rtl/chbd_checker.sv
// Port-level checker for the canonical Huffman bit decoder, bound to the top.
// Depends on chbd_pkg and canonical_huffman_bit_decoder_top_assert.svh.
`include "canonical_huffman_bit_decoder_top_assert.svh"

module chbd_checker #(
    parameter int MAX_CODE_BITS = chbd_pkg::MaxCodeBits
) (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           m_valid,
    input logic                           m_ready,
    input logic [chbd_pkg::StatusW-1:0]   m_status,
    input logic [chbd_pkg::ByteW-1:0]     m_symbol,
    input logic [chbd_pkg::CodeLenW-1:0]  m_code_length
);
    import chbd_pkg::*;

    // A stalled result keeps its payload until it is taken.
    `CHBD_ASSERT_NEXT(a_result_holds, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_status) && $stable(m_symbol) && $stable(m_code_length), "result changed while stalled")

    // Only a decoded symbol carries a symbol byte and a code length.
    `CHBD_ASSERT_NOW(a_no_symbol_fields, aclk, aresetn, m_valid && m_status != ST_SYMBOL, m_symbol == '0 && m_code_length == '0, "symbol fields set without a symbol")

    // A decoded code is between one and the longest code length.
    `CHBD_ASSERT_NOW(a_code_length_range, aclk, aresetn, m_valid && m_status == ST_SYMBOL, m_code_length != '0 && m_code_length <= MAX_CODE_BITS, "decoded code length out of range")

endmodule

bind canonical_huffman_bit_decoder_top chbd_checker #(
    .MAX_CODE_BITS (MAX_CODE_BITS)
) u_chbd_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_status      (m_status),
    .m_symbol      (m_symbol),
    .m_code_length (m_code_length)
);

>>> verif/huffman_decode_checker.sv
// Transfer monitor and result predictor for the canonical Huffman bit decoder.
// Depends on chbd_pkg; instantiated beside the block by the testbench top.
module huffman_decode_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    input  logic                           s_ready,
    input  logic [chbd_pkg::OpcodeW-1:0]   s_opcode,
    input  logic [chbd_pkg::SlotW-1:0]     s_slot,
    input  logic [chbd_pkg::ByteW-1:0]     s_byte_value,
    input  logic [chbd_pkg::TotalW-1:0]    s_symbol_total,
    input  logic                           s_code_bit,
    input  logic                           m_valid,
    input  logic                           m_ready,
    input  logic [chbd_pkg::StatusW-1:0]   m_status,
    input  logic [chbd_pkg::ByteW-1:0]     m_symbol,
    input  logic [chbd_pkg::CodeLenW-1:0]  m_code_length,
    output int unsigned                    mismatch_count,
    output int unsigned                    pending_results
);
    import chbd_pkg::*;

    typedef struct packed {
        status_t               status;
        logic [ByteW-1:0]      symbol;
        logic [CodeLenW-1:0]   code_length;
    } decode_result_t;

    // Shadow copy of the decoder tables and the partial code.
    logic [7:0]  len_count   [MaxCodeBits];
    logic [7:0]  sym_mem     [MaxSymbols];
    logic [16:0] first_code  [MaxCodeBits];
    logic [8:0]  first_index [MaxCodeBits];
    logic [15:0] code_acc;
    logic [4:0]  code_bits;
    logic        table_live;

    decode_result_t expected_q[$];
    decode_result_t want;

    function automatic void clear_partial_code();
        code_acc  = '0;
        code_bits = '0;
    endfunction

    // Checks the counts against the total and the code space, and derives the
    // first code and first symbol index of every length. A walk that runs out
    // of code space leaves the lengths already visited updated.
    function automatic bit derive_canonical_table(input int unsigned total);
        int unsigned sum;
        int unsigned code;
        int          l;
        sum  = 0;
        code = 0;
        if (total > MaxSymbols) return 1'b0;
        for (l = 0; l < MaxCodeBits; l++) sum += len_count[l];
        if (sum != total) return 1'b0;
        sum = 0;
        for (l = 0; l < MaxCodeBits; l++) begin
            first_code[l]  = code[16:0];
            first_index[l] = sum[8:0];
            code += len_count[l];
            sum  += len_count[l];
            if (code > (32'd1 << (l + 1))) return 1'b0;
            code = code << 1;
        end
        return 1'b1;
    endfunction

    function automatic decode_result_t predict_decoder_result(
        input opcode_t      op,
        input logic [7:0]   slot,
        input logic [7:0]   value,
        input logic [8:0]   total,
        input logic         code_bit
    );
        decode_result_t res;
        int unsigned    len;
        int unsigned    idx;
        int unsigned    c;
        int unsigned    first;
        int unsigned    cnt;
        int unsigned    last;
        int unsigned    li;
        int unsigned    lastcode;
        int unsigned    si;
        bit             alive;
        int             l;
        res.status      = ST_NONE;
        res.symbol      = '0;
        res.code_length = '0;
        case (op)
            OP_WRITE_COUNT: begin
                if (slot < MaxCodeBits) len_count[slot] = value;
                table_live = 1'b0;
                clear_partial_code();
            end
            OP_WRITE_SYMBOL: begin
                if (slot < MaxSymbols) sym_mem[slot] = value;
                table_live = 1'b0;
                clear_partial_code();
            end
            OP_COMMIT: begin
                table_live = derive_canonical_table(total);
                res.status = table_live ? ST_NONE : ST_TABLE_ERR;
                clear_partial_code();
            end
            default: begin
                if (!table_live) begin
                    res.status = ST_NOT_READY;
                end else begin
                    len   = code_bits + 1;
                    idx   = (len - 1) & 32'hF;
                    c     = ((int'(code_acc) << 1) | int'(code_bit)) & 32'hFFFF;
                    first = first_code[idx];
                    cnt   = len_count[idx];
                    if (c >= first && (c - first) < cnt) begin
                        si              = (first_index[idx] + (c - first)) & 32'hFF;
                        res.status      = ST_SYMBOL;
                        res.symbol      = sym_mem[si];
                        res.code_length = len[4:0];
                        clear_partial_code();
                    end else begin
                        // The prefix lives on only if it can still grow into
                        // a code no longer than the longest one in the table.
                        last  = 0;
                        alive = 1'b0;
                        for (l = 1; l <= MaxCodeBits; l++)
                            if (len_count[l-1] != 0) last = l;
                        if (last > len) begin
                            li       = last - 1;
                            lastcode = first_code[li] + len_count[li] - 1;
                            if (c <= (lastcode >> (last - len))) alive = 1'b1;
                        end
                        if (alive) begin
                            code_acc  = c[15:0];
                            code_bits = len[4:0];
                        end else begin
                            res.status = ST_INVALID;
                            clear_partial_code();
                        end
                    end
                end
            end
        endcase
        return res;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < MaxCodeBits; i++) begin
                len_count[i]   = '0;
                first_code[i]  = '0;
                first_index[i] = '0;
            end
            for (int i = 0; i < MaxSymbols; i++) sym_mem[i] = '0;
            clear_partial_code();
            table_live = 1'b0;
            expected_q.delete();
            mismatch_count  <= 0;
            pending_results <= 0;
        end else begin
            // Results trail their items through the queue and the result register, so
            // the result of this edge never belongs to the item taken at this edge.
            if (m_valid && m_ready) begin
                if (expected_q.size() == 0) begin
                    if (mismatch_count < 10)
                        $display("unexpected result transfer: status %0d symbol %0d length %0d",
                                 m_status, m_symbol, m_code_length);
                    mismatch_count <= mismatch_count + 1;
                end else begin
                    want = expected_q.pop_front();
                    if (m_status !== want.status || m_symbol !== want.symbol ||
                        m_code_length !== want.code_length) begin
                        if (mismatch_count < 10)
                            $display({"result mismatch: expected status %0d symbol %0d ",
                                      "length %0d, got status %0d symbol %0d length %0d"},
                                     want.status, want.symbol, want.code_length,
                                     m_status, m_symbol, m_code_length);
                        mismatch_count <= mismatch_count + 1;
                    end
                end
            end
            if (s_valid && s_ready)
                expected_q.push_back(predict_decoder_result(opcode_t'(s_opcode), s_slot,
                                                            s_byte_value, s_symbol_total,
                                                            s_code_bit));
            pending_results <= expected_q.size();
        end
    end

endmodule

>>> verif/canonical_huffman_bit_decoder_top_tb.sv
// Testbench top for the canonical Huffman bit decoder: clock, reset, table and
// bit-stream stimulus, receiver stalls, watchdog and verdict.
// Depends on chbd_pkg, canonical_huffman_bit_decoder_top and huffman_decode_checker.
module canonical_huffman_bit_decoder_top_tb;
    import chbd_pkg::*;

    // The longest stretch without any transfer in a correct run is a few
    // commit walks behind a stalled receiver, far below this limit.
    localparam int WatchdogLimit = 2000;
    localparam int ItemTarget    = 550;
    // Over the last items neither side idles.
    localparam int QuietTail     = 60;

    logic                  aclk           = 1'b0;
    logic                  aresetn        = 1'b0;
    logic                  s_valid        = 1'b0;
    logic                  s_ready;
    logic [OpcodeW-1:0]    s_opcode       = '0;
    logic [SlotW-1:0]      s_slot         = '0;
    logic [ByteW-1:0]      s_byte_value   = '0;
    logic [TotalW-1:0]     s_symbol_total = '0;
    logic                  s_code_bit     = 1'b0;
    logic                  m_valid;
    logic                  m_ready        = 1'b0;
    logic [StatusW-1:0]    m_status;
    logic [ByteW-1:0]      m_symbol;
    logic [CodeLenW-1:0]   m_code_length;

    int unsigned mismatch_count;
    int unsigned pending_results;

    // Stimulus bookkeeping: what the generator has written so far, so that a
    // commit that can pass never points at a symbol entry left unwritten.
    int unsigned items_sent   = 0;
    bit          idle_on      = 1'b0;
    int unsigned stall_left   = 0;
    int unsigned quiet_cycles = 0;
    logic [7:0]  count_mirror [MaxCodeBits];
    bit          sym_loaded   [MaxSymbols];
    logic [7:0]  count_plan   [MaxCodeBits];
    int unsigned plan_total;

    canonical_huffman_bit_decoder_top dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_opcode       (s_opcode),
        .s_slot         (s_slot),
        .s_byte_value   (s_byte_value),
        .s_symbol_total (s_symbol_total),
        .s_code_bit     (s_code_bit),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_symbol       (m_symbol),
        .m_code_length  (m_code_length)
    );

    huffman_decode_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_opcode        (s_opcode),
        .s_slot          (s_slot),
        .s_byte_value    (s_byte_value),
        .s_symbol_total  (s_symbol_total),
        .s_code_bit      (s_code_bit),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_symbol        (m_symbol),
        .m_code_length   (m_code_length),
        .mismatch_count  (mismatch_count),
        .pending_results (pending_results)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Receiver side: m_ready drops in bursts while idling is on, and stays high
    // otherwise.
    always @(negedge aclk) begin
        if (stall_left != 0) begin
            m_ready    <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            m_ready    <= 1'b0;
            stall_left <= $urandom_range(0, 6);
        end else begin
            m_ready <= 1'b1;
        end
    end

    // The watchdog ends a hung run: it counts cycles with no transfer on
    // either channel.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WatchdogLimit) begin
                $display("FAIL canonical_huffman_bit_decoder_top");
                $finish;
            end
        end
    end

    // Drives one item from a falling edge and returns at the falling edge
    // after its transfer. An idle burst may come first. Valid is only lowered
    // at the start of a burst, so back-to-back items keep it high. Once the
    // quiet tail is reached, idling stops on both sides even mid-sequence.
    task automatic send_item(input opcode_t op, input logic [7:0] slot,
                             input logic [7:0] value, input logic [8:0] total,
                             input logic bit_in);
        int unsigned gap;
        if (items_sent >= ItemTarget - QuietTail) idle_on = 1'b0;
        if (idle_on && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 7);
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid        <= 1'b1;
        s_opcode       <= op;
        s_slot         <= slot;
        s_byte_value   <= value;
        s_symbol_total <= total;
        s_code_bit     <= bit_in;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
        items_sent++;
        if (op == OP_WRITE_COUNT && slot < MaxCodeBits) count_mirror[slot] = value;
        if (op == OP_WRITE_SYMBOL) sym_loaded[slot] = 1'b1;
    endtask

    // Fields that an opcode does not use still carry random values.
    task automatic load_count(input logic [7:0] slot, input logic [7:0] value);
        send_item(OP_WRITE_COUNT, slot, value, 9'($urandom_range(0, 511)),
                  1'($urandom_range(0, 1)));
    endtask

    task automatic load_symbol(input logic [7:0] slot, input logic [7:0] value);
        send_item(OP_WRITE_SYMBOL, slot, value, 9'($urandom_range(0, 511)),
                  1'($urandom_range(0, 1)));
    endtask

    function automatic int unsigned mirror_count_sum();
        int unsigned sum;
        sum = 0;
        for (int l = 0; l < MaxCodeBits; l++) sum += count_mirror[l];
        return sum;
    endfunction

    // A commit can only pass when the total matches the counts, so in that
    // case every symbol index below the total is loaded first.
    task automatic commit_with_total(input int unsigned total);
        if (total <= MaxSymbols && total == mirror_count_sum())
            for (int i = 0; i < total; i++)
                if (!sym_loaded[i]) load_symbol(8'(i), 8'($urandom_range(0, 255)));
        send_item(OP_COMMIT, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  9'(total), 1'($urandom_range(0, 1)));
    endtask

    // Sends n decode bits; one_pct biases the stream, since deep tables need
    // long runs of the same bit to reach their longest codes.
    task automatic decode_bits(input int n, input int one_pct);
        repeat (n)
            send_item(OP_DECODE, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                      9'($urandom_range(0, 511)), $urandom_range(0, 99) < one_pct);
    endtask

    // Writes the planned counts: every slot that differs, plus a few that
    // already match so that rewrites of the same value also occur.
    task automatic apply_count_plan();
        for (int l = 0; l < MaxCodeBits; l++)
            if (count_plan[l] != count_mirror[l] || $urandom_range(0, 3) == 0)
                load_count(8'(l), count_plan[l]);
    endtask

    // Plans counts that fit the code space. Shorter lengths leave at least
    // one code free for the longer ones; the longest length either fills the
    // rest (a complete table) or takes part of it.
    task automatic plan_random_table(input int max_len, input int unsigned budget,
                                     input bit complete);
        int unsigned code;
        int unsigned cap;
        int unsigned cnt;
        code       = 0;
        plan_total = 0;
        for (int l = 0; l < MaxCodeBits; l++) count_plan[l] = '0;
        for (int l = 0; l < max_len; l++) begin
            cap = (32'd1 << (l + 1)) - code;
            if (l == max_len - 1)
                cnt = complete ? cap : $urandom_range(1, cap);
            else
                cnt = $urandom_range(0, (cap - 1 < 3) ? cap - 1 : 3);
            if (cnt > budget - plan_total) cnt = budget - plan_total;
            if (cnt > 255) cnt = 255;
            count_plan[l] = cnt[7:0];
            plan_total += cnt;
            code = (code + cnt) << 1;
        end
    endtask

    initial begin
        int          choice;
        int          lvl;
        bit          large_done;
        bit          chain_due;
        int unsigned wrong_total;
        large_done = 1'b0;
        chain_due  = 1'b1;
        for (int l = 0; l < MaxCodeBits; l++) count_mirror[l] = '0;
        for (int i = 0; i < MaxSymbols; i++) sym_loaded[i] = 1'b0;

        // Reset is released on a falling edge.
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed part. Bits before any commit report a table that is not
        // committed.
        send_item(OP_DECODE, 8'd0, 8'd0, 9'd0, 1'b0);
        send_item(OP_DECODE, 8'hFF, 8'hFF, 9'h1FF, 1'b1);
        // An empty table commits, and then every bit is an invalid code.
        commit_with_total(0);
        send_item(OP_DECODE, 8'd0, 8'd0, 9'd0, 1'b0);
        send_item(OP_DECODE, 8'd0, 8'd0, 9'd0, 1'b1);
        // Count slots past the longest length are ignored.
        load_count(8'd200, 8'hFF);
        load_count(8'hFF, 8'h00);
        // Totals above the symbol limit fail.
        commit_with_total(511);
        commit_with_total(257);
        // Counts that do not sum to the total fail.
        load_count(8'd0, 8'hFF);
        commit_with_total(254);
        // Three one-bit codes overflow the code space.
        load_count(8'd0, 8'd3);
        commit_with_total(3);
        send_item(OP_DECODE, 8'd0, 8'd0, 9'd0, 1'b1);
        // Symbol store extremes, then a single one-bit code: a zero decodes,
        // a one is an invalid prefix. A load after that forces a recommit.
        load_symbol(8'hFF, 8'hFF);
        load_symbol(8'd0, 8'd0);
        load_count(8'd0, 8'd1);
        commit_with_total(1);
        send_item(OP_DECODE, 8'd0, 8'd0, 9'd0, 1'b0);
        send_item(OP_DECODE, 8'd0, 8'd0, 9'd0, 1'b1);
        load_symbol(8'd1, 8'h5A);
        send_item(OP_DECODE, 8'd0, 8'd0, 9'd0, 1'b0);

        // Random part: mostly well-formed tables followed by bit streams,
        // with broken commits and loose noise mixed in.
        while (items_sent < ItemTarget) begin
            idle_on = (items_sent < ItemTarget - QuietTail) && ($urandom_range(0, 3) != 0);
            choice  = $urandom_range(0, 19);
            if (!large_done && items_sent > 150) choice = 18;
            if (chain_due) begin
                // One code of every length up to fifteen bits and two of
                // sixteen bits, so every code length can be decoded.
                chain_due = 1'b0;
                for (int l = 0; l < MaxCodeBits - 1; l++) count_plan[l] = 8'd1;
                count_plan[MaxCodeBits-1] = 8'd2;
                apply_count_plan();
                commit_with_total(17);
                decode_bits(48, 85);
            end else if (choice < 13) begin
                if ($urandom_range(0, 7) == 0)
                    plan_random_table($urandom_range(7, 16), 24, 1'($urandom_range(0, 1)));
                else
                    plan_random_table($urandom_range(1, 6), $urandom_range(1, 16),
                                      $urandom_range(0, 2) != 0);
                apply_count_plan();
                repeat ($urandom_range(0, 3))
                    load_symbol(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
                commit_with_total(plan_total);
                decode_bits($urandom_range(8, 40), $urandom_range(20, 80));
            end else if (choice < 15) begin
                if ($urandom_range(0, 1) == 0) begin
                    // Loose count writes and a total that cannot match.
                    repeat ($urandom_range(1, 3))
                        load_count(8'($urandom_range(0, 31)), 8'($urandom_range(0, 255)));
                    if ($urandom_range(0, 1) == 0)
                        wrong_total = $urandom_range(257, 511);
                    else
                        wrong_total = (mirror_count_sum() + 1) & 32'h1FF;
                    if (wrong_total == mirror_count_sum()) wrong_total = 511;
                    commit_with_total(wrong_total);
                end else begin
                    // A matching total over a length that holds one code too
                    // many for its code space.
                    plan_random_table($urandom_range(1, 6), $urandom_range(1, 12), 1'b0);
                    lvl = $urandom_range(0, 3);
                    plan_total = plan_total - count_plan[lvl] + (32'd1 << (lvl + 1)) + 1;
                    count_plan[lvl] = 8'((32'd1 << (lvl + 1)) + 1);
                    apply_count_plan();
                    commit_with_total(plan_total);
                end
                decode_bits(3, 50);
            end else if (choice < 18) begin
                repeat ($urandom_range(1, 6)) begin
                    case ($urandom_range(0, 3))
                        0: load_count(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
                        1: load_symbol(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
                        2: commit_with_total($urandom_range(0, 511));
                        default: decode_bits(1, 50);
                    endcase
                end
            end else if (!large_done) begin
                // A full table of 256 symbols at eight and nine bits, then
                // 255 codes of sixteen bits with the largest count value.
                large_done = 1'b1;
                for (int l = 0; l < MaxCodeBits; l++) count_plan[l] = '0;
                count_plan[7] = 8'd254;
                count_plan[8] = 8'd2;
                apply_count_plan();
                commit_with_total(256);
                decode_bits(60, 50);
                count_plan[7] = 8'd0;
                count_plan[8] = 8'd0;
                count_plan[MaxCodeBits-1] = 8'd255;
                apply_count_plan();
                commit_with_total(255);
                decode_bits(40, 3);
            end else begin
                chain_due = 1'b1;
            end
        end
        idle_on = 1'b0;
        s_valid <= 1'b0;

        // Drain every expected result, then give the block time to show any
        // stray result before the verdict.
        while (pending_results != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("PASS canonical_huffman_bit_decoder_top");
        end else begin
            $display("FAIL canonical_huffman_bit_decoder_top");
        end
        $finish;
    end

endmodule

>>> canonical_huffman_bit_decoder_top.f
+incdir+rtl
rtl/chbd_pkg.sv
rtl/chbd_front.sv
rtl/chbd_back.sv
rtl/canonical_huffman_bit_decoder_top.sv
rtl/chbd_checker.sv
verif/huffman_decode_checker.sv
verif/canonical_huffman_bit_decoder_top_tb.sv
